FILE: rtl/drhh_pkg.sv
// ----------------------------------------------------------------------------
// drhh_pkg
// Shared types and codes for the DRAM row-hit run histogram unit: request and
// status codes, histogram layout constants and the sequencer state type.
// ----------------------------------------------------------------------------
package drhh_pkg;

    // request codes
    localparam logic [1:0] REQ_ACTIVATE = 2'd0;
    localparam logic [1:0] REQ_ACCESS   = 2'd1;
    localparam logic [1:0] REQ_CLOSE    = 2'd2;
    localparam logic [1:0] REQ_READ     = 2'd3;

    // status codes
    localparam logic [1:0] STS_OK          = 2'd0;
    localparam logic [1:0] STS_ROW_MISS    = 2'd1;
    localparam logic [1:0] STS_EMPTY_CLOSE = 2'd2;

    // histogram layout: six run bins plus an all-bins total per row
    localparam int          BINS_PER_ROW = 7;
    localparam logic [2:0]  TOTAL_BIN    = 3'd6;
    localparam logic [2:0]  LAST_RUN_BIN = 3'd5;

    // run counter
    localparam int          RUN_W        = 3;
    localparam logic [2:0]  RUN_SAT      = 3'd7;
    localparam logic [2:0]  RUN_LONG     = 3'd6;

    localparam int          OUT_W        = 32;

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_BUMP_RD,
        ST_BUMP_WR,
        ST_FINISH
    } drhh_state_t;

endpackage

FILE: rtl/dram_row_hit_run_histogram_unit.sv
// flow: an accepted transaction goes through ST_LOOK and ST_FINISH to its result;
// a close that files a run adds four read-modify-write passes in between, each a
// histogram read in ST_BUMP_RD and a write in ST_BUMP_WR. ST_FINISH waits while
// result_stall holds a pending result; a new transaction is taken only in ST_IDLE.
// reset: row-open bits clear at once; the histogram memory is then swept to zero,
// one entry a cycle, NUM_CHIPS*(NUM_BANKS+1)*7 entries (952 at defaults), stall high.
// ----------------------------------------------------------------------------
// dram_row_hit_run_histogram_unit
// Tracks open rows and row-hit runs per chip and bank, files runs into a
// saturating histogram held in a synchronous memory and serves counter reads.
// ----------------------------------------------------------------------------
module dram_row_hit_run_histogram_unit #(
    parameter int NUM_CHIPS  = 8,
    parameter int NUM_BANKS  = 16,
    parameter int ROW_BITS   = 16,
    parameter int COUNT_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  req_type,
    input  logic [2:0]  chip,
    input  logic [4:0]  bank,
    input  logic [15:0] row,
    input  logic [2:0]  bin,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [1:0]  status,
    output logic [31:0] count_value
);

    localparam int SLOTS      = NUM_CHIPS * NUM_BANKS;
    localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int HIST_DEPTH = NUM_CHIPS * (NUM_BANKS + 1) * drhh_pkg::BINS_PER_ROW;
    localparam int HIST_W     = $clog2(HIST_DEPTH);
    localparam int EXT_W      = (COUNT_BITS > drhh_pkg::OUT_W) ? COUNT_BITS
                                                               : drhh_pkg::OUT_W;

    typedef struct packed {
        logic [ROW_BITS-1:0]        row;
        logic [drhh_pkg::RUN_W-1:0] run;
    } slot_word_t;

    // storage
    slot_word_t            slot_mem [SLOTS];
    logic [COUNT_BITS-1:0] hist_mem [HIST_DEPTH];
    logic [SLOTS-1:0]      row_open_valid_reg;

    drhh_pkg::drhh_state_t state_reg, state_next;

    // registered transaction
    logic [1:0]          req_reg;
    logic [ROW_BITS-1:0] row_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [HIST_W-1:0]   hbank_reg;
    logic [HIST_W-1:0]   htot_reg;
    logic                ev_ok_reg;
    logic                rd_ok_reg;
    logic [2:0]          sel_bin_reg;
    logic [1:0]          step_reg;
    logic [HIST_W-1:0]   clr_cnt_reg;
    logic [1:0]          res_status_reg;
    logic [31:0]         res_value_reg;

    // memory read data
    slot_word_t            slot_rd_reg;
    logic [COUNT_BITS-1:0] hist_rd_reg;

    // output register
    logic        result_valid_reg;
    logic [1:0]  status_reg;
    logic [31:0] count_value_reg;

    // control and datapath signals
    logic                  accept;
    logic                  out_free;
    logic [SLOT_W-1:0]     slot_in_idx;
    logic [HIST_W-1:0]     hist_in_idx;
    logic [HIST_W-1:0]     hbank_in;
    logic [HIST_W-1:0]     htot_in;
    logic                  ev_ok_in;
    logic                  rd_ok_in;
    logic [ROW_BITS-1:0]   row_in;
    logic                  cur_valid;
    logic [2:0]            run_cur;
    logic                  row_hit;
    logic [HIST_W-1:0]     bump_addr;
    logic [COUNT_BITS-1:0] hist_inc;
    logic [EXT_W-1:0]      hist_ext;
    logic                  slot_we;
    slot_word_t            slot_wdata;
    logic                  set_valid;
    logic                  hist_we;
    logic [HIST_W-1:0]     hist_waddr;
    logic [COUNT_BITS-1:0] hist_wdata;
    logic [HIST_W-1:0]     hist_raddr;
    logic                  look_start_bump;
    logic [1:0]            look_status;
    logic [31:0]           look_value;
    logic [2:0]            look_bin;

    // handshake
    assign item_stall   = (state_reg != drhh_pkg::ST_IDLE);
    assign accept       = item_valid && !item_stall;
    assign out_free     = !result_valid_reg || !result_stall;
    assign result_valid = result_valid_reg;
    assign status       = status_reg;
    assign count_value  = count_value_reg;

    // address generation from the incoming transaction
    assign row_in      = ROW_BITS'(row);
    assign slot_in_idx = SLOT_W'(32'(chip) * NUM_BANKS + 32'(bank));
    assign hbank_in    = HIST_W'((32'(chip) * (NUM_BANKS + 1) + 32'(bank))
                                 * drhh_pkg::BINS_PER_ROW);
    assign htot_in     = HIST_W'((32'(chip) * (NUM_BANKS + 1) + NUM_BANKS)
                                 * drhh_pkg::BINS_PER_ROW);
    assign hist_in_idx = hbank_in + HIST_W'(bin);
    assign ev_ok_in    = (req_type != drhh_pkg::REQ_READ) && (32'(chip) < NUM_CHIPS)
                         && (32'(bank) < NUM_BANKS);
    assign rd_ok_in    = (32'(chip) < NUM_CHIPS) && (32'(bank) <= NUM_BANKS)
                         && (bin <= drhh_pkg::TOTAL_BIN);

    // slot lookup results
    assign cur_valid = row_open_valid_reg[slot_reg];
    assign run_cur   = cur_valid ? slot_rd_reg.run : '0;
    assign row_hit   = cur_valid && (slot_rd_reg.row == row_reg);

    // counter update address and saturating increment
    assign bump_addr = (step_reg[0] ? htot_reg : hbank_reg)
                       + HIST_W'(step_reg[1] ? drhh_pkg::TOTAL_BIN : sel_bin_reg);
    assign hist_inc  = (hist_rd_reg == '1) ? hist_rd_reg : hist_rd_reg + 1'b1;
    assign hist_ext  = EXT_W'(hist_rd_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            drhh_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == HIST_W'(HIST_DEPTH - 1))
                    state_next = drhh_pkg::ST_IDLE;
            end
            drhh_pkg::ST_IDLE:
            begin
                if (accept)
                    state_next = drhh_pkg::ST_LOOK;
            end
            drhh_pkg::ST_LOOK:
            begin
                state_next = look_start_bump ? drhh_pkg::ST_BUMP_RD : drhh_pkg::ST_FINISH;
            end
            drhh_pkg::ST_BUMP_RD:
            begin
                state_next = drhh_pkg::ST_BUMP_WR;
            end
            drhh_pkg::ST_BUMP_WR:
            begin
                state_next = (step_reg == 2'd3) ? drhh_pkg::ST_FINISH : drhh_pkg::ST_BUMP_RD;
            end
            drhh_pkg::ST_FINISH:
            begin
                if (out_free)
                    state_next = drhh_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = drhh_pkg::ST_IDLE;
            end
        endcase
    end

    // transaction decode after the slot and histogram reads
    always_comb
    begin
        look_start_bump = 1'b0;
        look_status     = drhh_pkg::STS_OK;
        look_value      = '0;
        look_bin        = (run_cur >= drhh_pkg::RUN_LONG) ? drhh_pkg::LAST_RUN_BIN
                                                          : run_cur - 3'd1;
        slot_we         = 1'b0;
        set_valid       = 1'b0;
        slot_wdata.row  = row_reg;
        slot_wdata.run  = '0;
        case (req_reg)
            drhh_pkg::REQ_READ:
            begin
                if (rd_ok_reg)
                    look_value = hist_ext[31:0];
            end
            drhh_pkg::REQ_ACTIVATE:
            begin
                if (ev_ok_reg && state_reg == drhh_pkg::ST_LOOK)
                begin
                    slot_we   = 1'b1;
                    set_valid = 1'b1;
                end
            end
            drhh_pkg::REQ_ACCESS:
            begin
                if (ev_ok_reg)
                begin
                    if (row_hit)
                    begin
                        slot_we        = (state_reg == drhh_pkg::ST_LOOK);
                        slot_wdata.run = (run_cur == drhh_pkg::RUN_SAT) ? run_cur
                                                                        : run_cur + 3'd1;
                    end
                    else
                    begin
                        look_status = drhh_pkg::STS_ROW_MISS;
                    end
                end
            end
            drhh_pkg::REQ_CLOSE:
            begin
                if (ev_ok_reg)
                begin
                    if (run_cur == '0)
                        look_status = drhh_pkg::STS_EMPTY_CLOSE;
                    else
                        look_start_bump = 1'b1;
                end
            end
            default:
            begin
                look_value = '0;
            end
        endcase
    end

    // histogram memory port control
    always_comb
    begin
        hist_we    = 1'b0;
        hist_waddr = bump_addr;
        hist_wdata = hist_inc;
        hist_raddr = bump_addr;
        case (state_reg)
            drhh_pkg::ST_CLEAR:
            begin
                hist_we    = 1'b1;
                hist_waddr = clr_cnt_reg;
                hist_wdata = '0;
            end
            drhh_pkg::ST_IDLE:
            begin
                hist_raddr = hist_in_idx;
            end
            drhh_pkg::ST_BUMP_WR:
            begin
                hist_we = 1'b1;
            end
            default:
            begin
                hist_we = 1'b0;
            end
        endcase
    end

    // slot memory: open row and run length, registered read
    always_ff @(posedge clk)
    begin
        if (slot_we)
            slot_mem[slot_reg] <= slot_wdata;
        slot_rd_reg <= slot_mem[slot_in_idx];
    end

    // histogram memory: saturating counters, registered read
    always_ff @(posedge clk)
    begin
        if (hist_we)
            hist_mem[hist_waddr] <= hist_wdata;
        hist_rd_reg <= hist_mem[hist_raddr];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= drhh_pkg::ST_CLEAR;
            clr_cnt_reg        <= '0;
            row_open_valid_reg <= '0;
            step_reg           <= '0;
            result_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == drhh_pkg::ST_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (set_valid)
                row_open_valid_reg[slot_reg] <= 1'b1;
            if (state_reg == drhh_pkg::ST_LOOK)
                step_reg <= '0;
            else if (state_reg == drhh_pkg::ST_BUMP_WR)
                step_reg <= step_reg + 2'd1;
            if (state_reg == drhh_pkg::ST_FINISH && out_free)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    // transaction and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg   <= req_type;
            row_reg   <= row_in;
            slot_reg  <= slot_in_idx;
            hbank_reg <= hbank_in;
            htot_reg  <= htot_in;
            ev_ok_reg <= ev_ok_in;
            rd_ok_reg <= rd_ok_in;
        end
        if (state_reg == drhh_pkg::ST_LOOK)
        begin
            sel_bin_reg    <= look_bin;
            res_status_reg <= look_status;
            res_value_reg  <= look_value;
        end
        if (state_reg == drhh_pkg::ST_FINISH && out_free)
        begin
            status_reg      <= res_status_reg;
            count_value_reg <= res_value_reg;
        end
    end

endmodule
